// ===== src/gds_pkg.sv =====
// Shared types, constants and helpers for the 2x gaussian downsampler.
package gds_pkg;

   localparam int MaxSourceWidth = 4096;
   localparam int MaxSourceHeight = 4096;
   localparam int ColWidth = $clog2(MaxSourceWidth);
   localparam int RowWidth = 12;
   localparam int LineAddrWidth = ColWidth + 2;
   localparam int LineDepth = 4 * MaxSourceWidth;

   localparam logic [2:0] RegSourceWidth = 3'd0;
   localparam logic [2:0] RegSourceHeight = 3'd1;
   localparam logic [2:0] RegWeightM2 = 3'd2;
   localparam logic [2:0] RegWeightM1 = 3'd3;
   localparam logic [2:0] RegWeightC = 3'd4;
   localparam logic [2:0] RegWeightP1 = 3'd5;
   localparam logic [2:0] RegWeightP2 = 3'd6;
   localparam logic [2:0] RegNormScale = 3'd7;

   typedef struct packed {
      logic [12:0] source_width;
      logic [12:0] source_height;
      logic [15:0] weight0;
      logic [15:0] weight1;
      logic [15:0] weight2;
      logic [15:0] weight3;
      logic [15:0] weight4;
      logic [31:0] norm_scale;
   } cfg_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic                     rd_issue;   // read 4 line-store taps at col
      logic                     shift;      // shift window, write pixel
      logic                     acc_clear;
      logic                     acc_step;   // one tap row multiply-accumulate
      logic [2:0]               tap_row;
      logic                     norm_step;
      logic [2:0]               row_sel_base;
      logic [ColWidth-1:0]      col;
      logic [1:0]               row_mod;
      logic [4:0][2:0]          wc;
      logic [4:0][2:0]          wr;
   } cmd_type;

   // Clamp v to 0..lim-1 then map into window index (v + 4 - cur), clamped 0..4.
   function automatic logic [2:0] win_index(input logic signed [14:0] v,
                                            input logic signed [14:0] lim,
                                            input logic signed [14:0] cur);
      logic signed [14:0] cc;
      logic signed [14:0] wi;
      cc = v;
      if (cc < 0) cc = 0;
      if (cc > lim - 15'sd1) cc = lim - 15'sd1;
      wi = cc + 15'sd4 - cur;
      if (wi < 0) wi = 0;
      if (wi > 15'sd4) wi = 15'sd4;
      return wi[2:0];
   endfunction

endpackage

// ===== src/gds_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module gds_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== src/gds_datapath.sv =====
// Line store, window registers and multiply-accumulate filter datapath.
module gds_datapath (
   input  logic                 clock,
   input  gds_pkg::cfg_type     cfg,
   input  gds_pkg::cmd_type     cmd,
   input  logic [31:0]          pixel,
   output logic [7:0]           res [4]
);
   logic [31:0] rd_data [4];
   logic [31:0] win_ff [5][5];
   logic [31:0] sel_ff [5];
   logic [23:0] prod_ff [4][5];
   logic [47:0] acc_ff [4];
   logic [26:0] inner_ff [4];
   logic [7:0]  res_ff [4];
   logic [15:0] w [5];

   assign w[0] = cfg.weight0;
   assign w[1] = cfg.weight1;
   assign w[2] = cfg.weight2;
   assign w[3] = cfg.weight3;
   assign w[4] = cfg.weight4;

   // One RAM per line buffer; line k holds source rows k, k+4, k+8, ...
   for (genvar m = 0; m < 4; m++) begin : g_lines
      gds_ram #(.Width(32), .Depth(gds_pkg::MaxSourceWidth)) u_line (
         .clock  (clock),
         .wr_en  (cmd.shift && (cmd.row_mod == 2'(m))),
         .wr_addr(cmd.col),
         .wr_data(pixel),
         .rd_en  (cmd.rd_issue),
         .rd_addr(cmd.col),
         .rd_data(rd_data[m])
      );
   end

   // Window shift; column 4 receives the line reads (oldest row first) and the new pixel.
   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         for (int k = 0; k < 4; k++)
            for (int m = 0; m < 5; m++) win_ff[k][m] <= win_ff[k+1][m];
         for (int m = 0; m < 4; m++) win_ff[4][m] <= rd_data[2'(cmd.row_mod + 2'(m))];
         win_ff[4][4] <= pixel;
      end
   end

   // Stage 1: select tap row pixels; stage 2: per-tap products; stage 3: inner sum.
   always_ff @(posedge clock) begin
      for (int j = 0; j < 5; j++) sel_ff[j] <= win_ff[cmd.wc[j]][cmd.wr[cmd.tap_row]];
      for (int ch = 0; ch < 4; ch++)
         for (int j = 0; j < 5; j++)
            prod_ff[ch][j] <= 24'(w[j]) * 24'(sel_ff[j][ch*8 +: 8]);
      for (int ch = 0; ch < 4; ch++)
         inner_ff[ch] <= 27'(prod_ff[ch][0]) + 27'(prod_ff[ch][1]) + 27'(prod_ff[ch][2])
                         + 27'(prod_ff[ch][3]) + 27'(prod_ff[ch][4]);
   end

   // Accumulate inner*w_i, then normalize in two 48x16 halves.
   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         for (int ch = 0; ch < 4; ch++) acc_ff[ch] <= '0;
      end else if (cmd.acc_step) begin
         for (int ch = 0; ch < 4; ch++)
            acc_ff[ch] <= acc_ff[ch] + 48'(inner_ff[ch]) * 48'(w[cmd.row_sel_base]);
      end
      if (cmd.norm_step) begin
         for (int ch = 0; ch < 4; ch++) begin
            logic [63:0] hi, lo, v;
            hi = 64'(acc_ff[ch]) * 64'(cfg.norm_scale[31:16]);
            lo = 64'(acc_ff[ch]) * 64'(cfg.norm_scale[15:0]);
            v = (hi + (lo >> 16)) >> 32;
            res_ff[ch] <= (v > 64'd255) ? 8'd255 : v[7:0];
         end
      end
   end

   for (genvar ch = 0; ch < 4; ch++) begin : g_res
      assign res[ch] = res_ff[ch];
   end
endmodule

// ===== src/gds_ctrl.sv =====
// Controller: counters, tap sequencing and output handshake.
module gds_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  gds_pkg::cfg_type      cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_pixel,
   output logic [31:0]           pixel,
   output gds_pkg::cmd_type      cmd,
   input  logic [7:0]            res [4],
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [54:0]           rsp_tdata
);
   localparam int CW = gds_pkg::ColWidth;
   typedef enum logic [2:0] {S_IDLE, S_READ, S_SHIFT, S_ACC, S_NORM, S_OUT} state_type;

   state_type state_ff;
   logic [CW-1:0] col_ff;
   logic [11:0] row_ff;
   logic [31:0] pix_ff;
   logic [3:0]  cnt_ff;
   logic [10:0] ox_ff, oy_ff;
   logic        last_ff;
   logic [2:0]  wc_ff [5];
   logic [2:0]  wr_ff [5];

   logic [12:0] w_eff, h_eff;
   logic [12:0] c_eff, r_eff;
   logic [11:0] ow, oh;
   logic        tx_ok, ty_ok;
   logic [11:0] tx, ty;

   always_comb begin
      w_eff = (cfg.source_width == 0) ? 13'd1 :
              (cfg.source_width > 13'(gds_pkg::MaxSourceWidth)) ?
              13'(gds_pkg::MaxSourceWidth) : cfg.source_width;
      h_eff = (cfg.source_height == 0) ? 13'd1 :
              (cfg.source_height > 13'(gds_pkg::MaxSourceHeight)) ?
              13'(gds_pkg::MaxSourceHeight) : cfg.source_height;
      c_eff = (13'(col_ff) >= w_eff) ? 13'd0 : 13'(col_ff);
      r_eff = (13'(row_ff) >= h_eff) ? 13'd0 : 13'(row_ff);
      ow = w_eff[12:1];
      oh = h_eff[12:1];
      tx_ok = 1'b0; tx = '0;
      if (ow != 0) begin
         if (c_eff == {ow, 1'b0} - 13'd1) begin tx_ok = 1'b1; tx = ow - 12'd1; end
         else if (c_eff >= 2 && !c_eff[0] && (c_eff[12:1] - 12'd1) < ow - 12'd1) begin
            tx_ok = 1'b1; tx = c_eff[12:1] - 12'd1;
         end
      end
      ty_ok = 1'b0; ty = '0;
      if (oh != 0) begin
         if (r_eff == {oh, 1'b0} - 13'd1) begin ty_ok = 1'b1; ty = oh - 12'd1; end
         else if (r_eff >= 2 && !r_eff[0] && (r_eff[12:1] - 12'd1) < oh - 12'd1) begin
            ty_ok = 1'b1; ty = r_eff[12:1] - 12'd1;
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign pixel = pix_ff;

   always_comb begin
      cmd = '0;
      cmd.col = c_eff[CW-1:0];
      cmd.row_mod = r_eff[1:0];
      cmd.rd_issue = (state_ff == S_READ);
      cmd.shift = (state_ff == S_SHIFT);
      cmd.acc_clear = (state_ff == S_SHIFT);
      cmd.tap_row = (cnt_ff < 5) ? cnt_ff[2:0] : 3'd0;
      // inner sum for row i is ready once it has passed the select, product and inner-sum registers
      cmd.acc_step = (state_ff == S_ACC) && cnt_ff >= 3 && cnt_ff < 8;
      cmd.row_sel_base = (cnt_ff >= 3 && cnt_ff < 8) ? 3'(cnt_ff - 4'd3) : 3'd0;
      cmd.norm_step = (state_ff == S_NORM);
      for (int k = 0; k < 5; k++) begin
         cmd.wc[k] = wc_ff[k];
         cmd.wr[k] = wr_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff <= '0;
         row_ff <= '0;
         rsp_tvalid <= 1'b0;
         cnt_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: if (req_tvalid) begin
               pix_ff <= req_pixel;
               state_ff <= S_READ;
            end
            S_READ: state_ff <= S_SHIFT;
            S_SHIFT: begin
               for (int k = 0; k < 5; k++) begin
                  wc_ff[k] <= gds_pkg::win_index(15'(signed'({1'b0, tx, 1'b0})) + 15'(k) - 15'sd2,
                     15'(signed'({1'b0, ow, 1'b0})), 15'(signed'({1'b0, c_eff})));
                  wr_ff[k] <= gds_pkg::win_index(15'(signed'({1'b0, ty, 1'b0})) + 15'(k) - 15'sd2,
                     15'(signed'({1'b0, oh, 1'b0})), 15'(signed'({1'b0, r_eff})));
               end
               ox_ff <= tx[10:0];
               oy_ff <= ty[10:0];
               last_ff <= (tx == ow - 12'd1) && (ty == oh - 12'd1);
               cnt_ff <= '0;
               if (c_eff + 13'd1 >= w_eff) begin
                  col_ff <= '0;
                  row_ff <= (r_eff + 13'd1 >= h_eff) ? 12'd0 : 12'(r_eff + 13'd1);
               end else begin
                  col_ff <= CW'(c_eff + 13'd1);
                  row_ff <= r_eff[11:0];
               end
               state_ff <= (tx_ok && ty_ok) ? S_ACC : S_IDLE;
            end
            S_ACC: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd7) state_ff <= S_NORM;
            end
            S_NORM: begin
               rsp_tvalid <= 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp_tready) begin
               rsp_tvalid <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tdata = {last_ff, oy_ff, ox_ff, res[3], res[2], res[1], res[0]};
endmodule

// ===== src/gaussian_downsample_2x.sv =====
// Top level of the 5x5 gaussian 2x downsampler.
//
//  channel  direction  tdata fields (low bit up)
//  req_     in         src_red, src_green, src_blue, src_alpha
//  rsp_     out        out_red..out_alpha, out_col, out_row, frame_last (in tdata, padded to 56)
//  csr_     in         index 3 bits, data 32 bits
//
// A source pixel passes through accept, line store read and window shift; one that
// completes an output pixel then runs its five tap rows through the shared
// multiply-accumulate pipeline, is normalized and is handed off, which waits
// for rsp_tready.
// Reset is synchronous; state and counters clear, while the window control and the
// line store are not cleared. A stalled output holds the block until it is taken.
module gaussian_downsample_2x (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // src_red, src_green, src_blue, src_alpha
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // out_red..alpha, out_col, out_row, frame_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   gds_pkg::cfg_type cfg_ff;
   gds_pkg::cmd_type cmd;
   logic [31:0] pixel;
   logic [7:0]  res [4];
   logic [54:0] tdata;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width <= 13'd4096;
         cfg_ff.source_height <= 13'd4096;
         cfg_ff.weight0 <= 16'd4096;
         cfg_ff.weight1 <= 16'd16384;
         cfg_ff.weight2 <= 16'd24576;
         cfg_ff.weight3 <= 16'd16384;
         cfg_ff.weight4 <= 16'd4096;
         cfg_ff.norm_scale <= 32'd65536;
      end else if (csr_valid) begin
         case (csr_index)
            gds_pkg::RegSourceWidth: cfg_ff.source_width <= csr_data[12:0];
            gds_pkg::RegSourceHeight: cfg_ff.source_height <= csr_data[12:0];
            gds_pkg::RegWeightM2: cfg_ff.weight0 <= csr_data[15:0];
            gds_pkg::RegWeightM1: cfg_ff.weight1 <= csr_data[15:0];
            gds_pkg::RegWeightC: cfg_ff.weight2 <= csr_data[15:0];
            gds_pkg::RegWeightP1: cfg_ff.weight3 <= csr_data[15:0];
            gds_pkg::RegWeightP2: cfg_ff.weight4 <= csr_data[15:0];
            gds_pkg::RegNormScale: cfg_ff.norm_scale <= csr_data;
            default: ;
         endcase
      end
   end

   gds_ctrl u_ctrl (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_pixel(req_tdata),
      .pixel(pixel), .cmd(cmd), .res(res),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(tdata)
   );

   gds_datapath u_dp (
      .clock(clock), .cfg(cfg_ff), .cmd(cmd), .pixel(pixel), .res(res)
   );

   assign rsp_tdata = {1'b0, tdata};
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the 5x5 gaussian 2x downsampler.
module testbench;

   localparam int IdleLimit = 2000;   // cycles without any beat before giving up
   localparam int DrainCycles = 30;   // covers the pixel pipeline of a no-result beat
   localparam int HoldCycles = 300;   // long receiver hold-off to back up the input

   typedef struct {
      logic [7:0]  chan [4];
      logic [10:0] col;
      logic [10:0] row;
      logic        last;
   } mip_pixel_type;

   // Mirrors the downsampler state and keeps the expected output pixels.
   class mip_scoreboard;
      logic [12:0] width_reg;
      logic [12:0] height_reg;
      logic [15:0] weight [5];
      logic [31:0] norm;
      logic [31:0] lines [gds_pkg::LineDepth];
      logic [31:0] win [5][5];   // [column, oldest first][row, oldest first]
      int          col_cnt;
      int          row_cnt;
      mip_pixel_type pending [$];
      int          errors;

      function new();
         width_reg = 13'd4096;
         height_reg = 13'd4096;
         weight = '{16'd4096, 16'd16384, 16'd24576, 16'd16384, 16'd4096};
         norm = 32'd65536;
         foreach (lines[i]) lines[i] = '0;
         foreach (win[i, j]) win[i][j] = '0;
         col_cnt = 0;
         row_cnt = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [31:0] data);
         case (index)
            gds_pkg::RegSourceWidth: width_reg = data[12:0];
            gds_pkg::RegSourceHeight: height_reg = data[12:0];
            gds_pkg::RegWeightM2: weight[0] = data[15:0];
            gds_pkg::RegWeightM1: weight[1] = data[15:0];
            gds_pkg::RegWeightC: weight[2] = data[15:0];
            gds_pkg::RegWeightP1: weight[3] = data[15:0];
            gds_pkg::RegWeightP2: weight[4] = data[15:0];
            gds_pkg::RegNormScale: norm = data;
            default: ;
         endcase
      endfunction

      function int eff_width();
         return (width_reg < 1) ? 1 :
                (width_reg > gds_pkg::MaxSourceWidth) ? gds_pkg::MaxSourceWidth
                                                      : int'(width_reg);
      endfunction

      function int eff_height();
         return (height_reg < 1) ? 1 :
                (height_reg > gds_pkg::MaxSourceHeight) ? gds_pkg::MaxSourceHeight
                                                        : int'(height_reg);
      endfunction

      function int clamp_to(int v, int lim);
         return (v < 0) ? 0 : (v > lim - 1) ? lim - 1 : v;
      endfunction

      // Output index completed by source index s, or -1.
      function int out_index(int s, int n);
         if (n == 0) return -1;
         if (s == 2 * n - 1) return n - 1;
         if (s >= 2 && s % 2 == 0 && (s - 2) / 2 < n - 1) return (s - 2) / 2;
         return -1;
      endfunction

      function logic [7:0] filter(logic [31:0] sel [5][5], int shift);
         logic [63:0] sum;
         logic [63:0] inner;
         logic [95:0] prod;
         sum = '0;
         for (int i = 0; i < 5; i++) begin
            inner = '0;
            for (int j = 0; j < 5; j++)
               inner += 64'(weight[j]) * 64'((sel[i][j] >> shift) & 32'hFF);
            sum += inner * 64'(weight[i]);
         end
         prod = 96'(sum) * 96'(norm);
         prod = prod >> 48;
         return (prod > 255) ? 8'hFF : prod[7:0];
      endfunction

      function void note_pixel(logic [31:0] px);
         int w, h, c, r, ow, oh, x, y, rr, wr, cc, wc;
         logic [31:0] sel [5][5];
         mip_pixel_type e;
         w = eff_width();
         h = eff_height();
         if (col_cnt >= w) col_cnt = 0;
         if (row_cnt >= h) row_cnt = 0;
         c = col_cnt;
         r = row_cnt;
         for (int k = 0; k < 4; k++)
            for (int m = 0; m < 5; m++) win[k][m] = win[k + 1][m];
         for (int m = 0; m < 4; m++)
            win[4][m] = lines[((r + m) & 3) * gds_pkg::MaxSourceWidth + c];
         win[4][4] = px;
         lines[(r & 3) * gds_pkg::MaxSourceWidth + c] = px;
         ow = w / 2;
         oh = h / 2;
         y = out_index(r, oh);
         x = out_index(c, ow);
         if (x >= 0 && y >= 0) begin
            for (int i = 0; i < 5; i++) begin
               rr = clamp_to(2 * y + i - 2, 2 * oh);
               wr = clamp_to(rr + 4 - r, 5);
               for (int j = 0; j < 5; j++) begin
                  cc = clamp_to(2 * x + j - 2, 2 * ow);
                  wc = clamp_to(cc + 4 - c, 5);
                  sel[i][j] = win[wc][wr];
               end
            end
            for (int k = 0; k < 4; k++) e.chan[k] = filter(sel, 8 * k);
            e.col = x[10:0];
            e.row = y[10:0];
            e.last = (x == ow - 1 && y == oh - 1);
            pending.push_back(e);
         end
         col_cnt = c + 1;
         if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
         end
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check(logic [55:0] d);
         mip_pixel_type e;
         if (pending.size() == 0) begin
            report($sformatf("output beat %h with nothing expected", d));
            return;
         end
         e = pending.pop_front();
         for (int k = 0; k < 4; k++)
            if (d[8 * k +: 8] !== e.chan[k])
               report($sformatf("(%0d,%0d) channel %0d got %h want %h",
                                e.col, e.row, k, d[8 * k +: 8], e.chan[k]));
         if (d[42:32] !== e.col)
            report($sformatf("col got %0d want %0d", d[42:32], e.col));
         if (d[53:43] !== e.row)
            report($sformatf("row got %0d want %0d", d[53:43], e.row));
         if (d[54] !== e.last)
            report($sformatf("(%0d,%0d) frame_last got %b want %b",
                             e.col, e.row, d[54], e.last));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   gaussian_downsample_2x u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   mip_scoreboard mips = new();
   bit gappy_source;    // sender idles between beats
   bit gappy_sink;      // receiver stalls between beats
   bit hold_sink;       // one-shot long receiver hold-off
   int pixels_sent;
   int idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: any beat on any channel counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("gaussian_downsample_2x regression: fail");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold while the sender keeps pushing.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         stall = gappy_sink ? (($urandom_range(2) == 0) ? 0 : $urandom_range(11)) : 0;
         if (hold_sink) begin
            hold_sink = 1'b0;
            stall = HoldCycles;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         mips.check(rsp_tdata);
      end
   end

   task automatic csr_write(logic [2:0] index, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      mips.write_reg(index, data);
      csr_valid <= 1'b0;
   endtask

   // Writes all registers; upper junk on the size registers must be ignored.
   task automatic configure(int w, int h, logic [15:0] wt [5], logic [31:0] ns);
      csr_write(gds_pkg::RegSourceWidth, {$urandom_range(1) ? 19'($urandom) : 19'd0, 13'(w)});
      csr_write(gds_pkg::RegSourceHeight, {$urandom_range(1) ? 19'($urandom) : 19'd0, 13'(h)});
      csr_write(gds_pkg::RegWeightM2, {16'd0, wt[0]});
      csr_write(gds_pkg::RegWeightM1, {16'd0, wt[1]});
      csr_write(gds_pkg::RegWeightC, {16'd0, wt[2]});
      csr_write(gds_pkg::RegWeightP1, {16'd0, wt[3]});
      csr_write(gds_pkg::RegWeightP2, {16'd0, wt[4]});
      csr_write(gds_pkg::RegNormScale, ns);
   endtask

   task automatic send_pixel(logic [31:0] px);
      int gap;
      gap = gappy_source ? (($urandom_range(2) == 0) ? 0 : $urandom_range(11)) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      do @(posedge clock); while (!req_tready);
      mips.note_pixel(px);
      pixels_sent++;
   endtask

   // Returns to idle: all results in, then the pipeline tail of no-result beats.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (mips.pending.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic logic [31:0] random_pixel();
      case ($urandom_range(7))
         0: return 32'hFFFF_FFFF;
         1: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   function automatic int random_size();
      case ($urandom_range(11))
         0: return $urandom_range(1);      // degenerate: no output
         1: return $urandom_range(13, 24);
         default: return $urandom_range(2, 12);
      endcase
   endfunction

   initial begin
      logic [15:0] wt [5];
      logic [15:0] gauss [5];
      logic [31:0] ns;
      longint unsigned wsum;
      int w, h, frames;
      gauss = '{16'd4096, 16'd16384, 16'd24576, 16'd16384, 16'd4096};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = gds_pkg::RegSourceWidth;
      csr_data = '0;
      gappy_source = 1'b0;
      gappy_sink = 1'b0;
      hold_sink = 1'b0;
      pixels_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Smallest frame, saturated and empty pixels, unit-gain gaussian.
      configure(2, 2, gauss, 32'd65536);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0);
      send_pixel(32'hFF00_FF00);
      send_pixel(32'h00FF_00FF);
      settle();
      // 5x5: odd last row and column dropped, walking bits through every channel.
      configure(5, 5, gauss, 32'd65536);
      for (int k = 0; k < 25; k++) send_pixel(32'h1 << (k + 7 * (k / 32)));
      settle();

      // Random part: sizes, weights and normalizer change per phase.
      hold_sink = 1'b1;
      for (int phase = 0; pixels_sent < 1900; phase++) begin
         gappy_source = ($urandom_range(3) != 0);
         gappy_sink = ($urandom_range(3) != 0);
         w = random_size();
         h = random_size();
         if (phase == 5) begin
            w = 0;         // clamps to a single column
         end else if (phase == 3) begin
            h = 0;
         end
         case ($urandom_range(5))
            0: wt = gauss;
            1: foreach (wt[i]) wt[i] = $urandom_range(1) ? 16'hFFFF : 16'h0;
            default: foreach (wt[i]) wt[i] = 16'($urandom);
         endcase
         wsum = 0;
         foreach (wt[i]) wsum += wt[i];
         case ($urandom_range(7))
            0: ns = 32'h0;
            1: ns = 32'hFFFF_FFFF;
            2: ns = $urandom;
            default: begin
               if (wsum == 0) ns = $urandom;
               else begin
                  wsum = (64'd1 << 48) / (wsum * wsum);
                  ns = (wsum > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(wsum);
                  ns = ns + 32'($urandom_range(ns / 8));
               end
            end
         endcase
         configure(w, h, wt, ns);
         frames = (w * h > 150) ? 1 : $urandom_range(1, 3);
         for (int f = 0; f < frames; f++)
            for (int p = 0; p < mips.eff_width() * mips.eff_height(); p++)
               send_pixel(random_pixel());
         settle();
      end

      if (mips.errors == 0 && mips.pending.size() == 0) begin
         $display("gaussian_downsample_2x regression: pass");
      end else begin
         $display("gaussian_downsample_2x regression: fail");
      end
      $finish;
   end

endmodule
